/* hw/rtl/si_pkg.sv */
// ----------------------------------------------------------------------------
// si_pkg: segment intersection shared types and constants
// Coordinate widths, derived datapath widths and the divider cell payload.
// ----------------------------------------------------------------------------
`default_nettype none

package si_pkg;

    localparam int CW = 24;          // coordinate width, 8 fraction bits
    localparam int DW = CW + 1;      // coordinate difference
    localparam int PW = 2 * DW;      // signed product of two differences
    localparam int RW = PW + 1;      // cross product sum, divider remainder
    localparam int AW = PW;          // magnitude of a normalized numerator
    localparam int HW = AW / 2;      // partial product split point
    localparam int NW = AW + CW;     // interpolation dividend
    localparam int QW = CW;          // quotient bits, one per cell

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] nq;           // dividend bits out at the top, quotient in
    } t_lane;

    typedef struct packed {
        logic                 hit;
        logic                 neg_x;
        logic                 neg_y;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic [RW-1:0]        den;
        t_lane                lx;
        t_lane                ly;
    } t_div;

endpackage

`default_nettype wire

/* hw/rtl/si_if.sv */
// ----------------------------------------------------------------------------
// si_if: segment intersection channels
// Segment pair input channel and crossing result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface si_seg_if;
    import si_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] first_start_x;
    logic signed [CW-1:0] first_start_y;
    logic signed [CW-1:0] first_end_x;
    logic signed [CW-1:0] first_end_y;
    logic signed [CW-1:0] second_start_x;
    logic signed [CW-1:0] second_start_y;
    logic signed [CW-1:0] second_end_x;
    logic signed [CW-1:0] second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

interface si_res_if;
    import si_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

`default_nettype wire

/* hw/rtl/si_cell.sv */
// ----------------------------------------------------------------------------
// si_cell: one restoring division step
// Shifts one dividend bit into each lane remainder, subtracts the
// denominator where it fits and hands the result to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module si_cell (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  si_pkg::t_div      i_d,
    output logic              o_valid,
    output si_pkg::t_div      o_d
);
    import si_pkg::*;

    logic  r_valid;
    t_div  r_d;
    t_div  n_d;

    function automatic t_lane step(input t_lane l, input logic [RW-1:0] den);
        logic [RW:0] t;
        logic        ge;
        t_lane       r;
        t      = {l.rem, l.nq[QW-1]};
        ge     = (t >= {1'b0, den});
        r.rem  = ge ? RW'(t - {1'b0, den}) : t[RW-1:0];
        r.nq   = {l.nq[QW-2:0], ge};
        return r;
    endfunction

    always_comb begin
        n_d    = i_d;
        n_d.lx = step(i_d.lx, i_d.den);
        n_d.ly = step(i_d.ly, i_d.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

`default_nettype wire

/* hw/rtl/si_front.sv */
// ----------------------------------------------------------------------------
// si_front: cross products, range test and interpolation dividend
// Six stages: differences, products, sums, sign normalize and range test,
// partial products, dividend assembly feeding the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module si_front (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    si_seg_if.sink        i_seg,
    output logic          o_valid,
    output si_pkg::t_div  o_d
);
    import si_pkg::*;

    logic [5:0] r_v;

    // stage 1
    logic signed [DW-1:0] r_s1_d1x, r_s1_d1y, r_s1_d2x, r_s1_d2y, r_s1_ox, r_s1_oy;
    logic signed [CW-1:0] r_s1_sx, r_s1_sy;
    // stage 2
    logic signed [PW-1:0] r_s2_pd1, r_s2_pd2, r_s2_pa1, r_s2_pa2, r_s2_pb1, r_s2_pb2;
    logic [CW-1:0]        r_s2_mx, r_s2_my;
    logic                 r_s2_nx, r_s2_ny;
    logic signed [CW-1:0] r_s2_sx, r_s2_sy;
    // stage 3
    logic signed [RW-1:0] r_s3_den, r_s3_a, r_s3_b;
    logic [CW-1:0]        r_s3_mx, r_s3_my;
    logic                 r_s3_nx, r_s3_ny;
    logic signed [CW-1:0] r_s3_sx, r_s3_sy;
    // stage 4
    logic [RW-1:0]        r_s4_den;
    logic [AW-1:0]        r_s4_a;
    logic                 r_s4_hit;
    logic [CW-1:0]        r_s4_mx, r_s4_my;
    logic                 r_s4_nx, r_s4_ny;
    logic signed [CW-1:0] r_s4_sx, r_s4_sy;
    // stage 5
    logic [HW+CW-1:0]     r_s5_xl, r_s5_xh, r_s5_yl, r_s5_yh;
    logic [RW-1:0]        r_s5_den;
    logic                 r_s5_hit, r_s5_nx, r_s5_ny;
    logic signed [CW-1:0] r_s5_sx, r_s5_sy;
    // stage 6
    t_div                 r_s6;

    logic signed [DW-1:0] n_d1x, n_d1y;
    logic signed [RW-1:0] n_den, n_a, n_b;
    logic [NW-1:0]        n_nx, n_ny;
    t_div                 n_s6;

    assign n_d1x = DW'(i_seg.first_end_x) - DW'(i_seg.first_start_x);
    assign n_d1y = DW'(i_seg.first_end_y) - DW'(i_seg.first_start_y);

    always_comb begin
        n_den = r_s3_den[RW-1] ? -r_s3_den : r_s3_den;
        n_a   = r_s3_den[RW-1] ? -r_s3_a   : r_s3_a;
        n_b   = r_s3_den[RW-1] ? -r_s3_b   : r_s3_b;
    end

    always_comb begin
        n_nx = NW'(r_s5_xl) + (NW'(r_s5_xh) << HW);
        n_ny = NW'(r_s5_yl) + (NW'(r_s5_yh) << HW);
        n_s6.hit    = r_s5_hit;
        n_s6.neg_x  = r_s5_nx;
        n_s6.neg_y  = r_s5_ny;
        n_s6.sx     = r_s5_sx;
        n_s6.sy     = r_s5_sy;
        n_s6.den    = r_s5_den;
        n_s6.lx.rem = RW'(n_nx[NW-1:QW]);
        n_s6.lx.nq  = n_nx[QW-1:0];
        n_s6.ly.rem = RW'(n_ny[NW-1:QW]);
        n_s6.ly.nq  = n_ny[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_seg.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_d1x <= n_d1x;
            r_s1_d1y <= n_d1y;
            r_s1_d2x <= DW'(i_seg.second_end_x) - DW'(i_seg.second_start_x);
            r_s1_d2y <= DW'(i_seg.second_end_y) - DW'(i_seg.second_start_y);
            r_s1_ox  <= DW'(i_seg.first_start_x) - DW'(i_seg.second_start_x);
            r_s1_oy  <= DW'(i_seg.first_start_y) - DW'(i_seg.second_start_y);
            r_s1_sx  <= i_seg.first_start_x;
            r_s1_sy  <= i_seg.first_start_y;

            r_s2_pd1 <= PW'(r_s1_d2y) * PW'(r_s1_d1x);
            r_s2_pd2 <= PW'(r_s1_d2x) * PW'(r_s1_d1y);
            r_s2_pa1 <= PW'(r_s1_d2x) * PW'(r_s1_oy);
            r_s2_pa2 <= PW'(r_s1_d2y) * PW'(r_s1_ox);
            r_s2_pb1 <= PW'(r_s1_d1x) * PW'(r_s1_oy);
            r_s2_pb2 <= PW'(r_s1_d1y) * PW'(r_s1_ox);
            r_s2_nx  <= r_s1_d1x[DW-1];
            r_s2_ny  <= r_s1_d1y[DW-1];
            r_s2_mx  <= r_s1_d1x[DW-1] ? CW'(-r_s1_d1x) : r_s1_d1x[CW-1:0];
            r_s2_my  <= r_s1_d1y[DW-1] ? CW'(-r_s1_d1y) : r_s1_d1y[CW-1:0];
            r_s2_sx  <= r_s1_sx;
            r_s2_sy  <= r_s1_sy;

            r_s3_den <= RW'(r_s2_pd1) - RW'(r_s2_pd2);
            r_s3_a   <= RW'(r_s2_pa1) - RW'(r_s2_pa2);
            r_s3_b   <= RW'(r_s2_pb1) - RW'(r_s2_pb2);
            r_s3_mx  <= r_s2_mx;
            r_s3_my  <= r_s2_my;
            r_s3_nx  <= r_s2_nx;
            r_s3_ny  <= r_s2_ny;
            r_s3_sx  <= r_s2_sx;
            r_s3_sy  <= r_s2_sy;

            r_s4_den <= n_den;
            r_s4_a   <= n_a[AW-1:0];
            r_s4_hit <= (n_den != '0) && !n_a[RW-1] && !n_b[RW-1]
                        && ($unsigned(n_a) <= $unsigned(n_den))
                        && ($unsigned(n_b) <= $unsigned(n_den));
            r_s4_mx  <= r_s3_mx;
            r_s4_my  <= r_s3_my;
            r_s4_nx  <= r_s3_nx;
            r_s4_ny  <= r_s3_ny;
            r_s4_sx  <= r_s3_sx;
            r_s4_sy  <= r_s3_sy;

            r_s5_xl  <= (HW+CW)'(r_s4_a[HW-1:0])  * (HW+CW)'(r_s4_mx);
            r_s5_xh  <= (HW+CW)'(r_s4_a[AW-1:HW]) * (HW+CW)'(r_s4_mx);
            r_s5_yl  <= (HW+CW)'(r_s4_a[HW-1:0])  * (HW+CW)'(r_s4_my);
            r_s5_yh  <= (HW+CW)'(r_s4_a[AW-1:HW]) * (HW+CW)'(r_s4_my);
            r_s5_den <= r_s4_den;
            r_s5_hit <= r_s4_hit;
            r_s5_nx  <= r_s4_nx;
            r_s5_ny  <= r_s4_ny;
            r_s5_sx  <= r_s4_sx;
            r_s5_sy  <= r_s4_sy;

            r_s6     <= n_s6;
        end
    end

    assign i_seg.ready = i_en;
    assign o_valid     = r_v[5];
    assign o_d         = r_s6;

endmodule

`default_nettype wire

/* hw/rtl/segment_intersection.sv */
// ----------------------------------------------------------------------------
// segment_intersection: 2D segment pair crossing test and crossing point
// Fixed-point cross products, inclusive range test without division, and
// interpolation along the first segment through a chain of divider cells.
//
//   channel   port    dir  contents
//   segments  i_seg   in   two segments, eight signed coordinates
//   result    o_res   out  hit flag, crossing x and y
//
// One transfer per cycle in and out unless the result is stalled; 6 front
// stages, one divider cell per quotient bit for 24 cells, one output register.
// The whole pipeline advances together; a stalled result holds every stage.
// Reset clears the valid bits only; no state survives between items.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    si_seg_if.sink    i_seg,
    si_res_if.source  o_res
);
    import si_pkg::*;

    logic                 w_en;
    logic                 w_v [0:QW];
    t_div                 w_d [0:QW];
    logic                 r_valid;
    logic                 r_hit;
    logic signed [CW-1:0] r_x, r_y;
    logic [CW-1:0]        n_offx, n_offy;

    assign w_en = !r_valid || o_res.ready;

    si_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_seg   (i_seg),
        .o_valid (w_v[0]),
        .o_d     (w_d[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_cell
        si_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_d     (w_d[g]),
            .o_valid (w_v[g+1]),
            .o_d     (w_d[g+1])
        );
    end

    assign n_offx = w_d[QW].neg_x ? -w_d[QW].lx.nq : w_d[QW].lx.nq;
    assign n_offy = w_d[QW].neg_y ? -w_d[QW].ly.nq : w_d[QW].ly.nq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= w_d[QW].hit;
            r_x   <= w_d[QW].hit ? w_d[QW].sx + $signed(n_offx) : '0;
            r_y   <= w_d[QW].hit ? w_d[QW].sy + $signed(n_offy) : '0;
        end
    end

    assign o_res.valid   = r_valid;
    assign o_res.hit     = r_hit;
    assign o_res.cross_x = r_x;
    assign o_res.cross_y = r_y;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.hit |-> o_res.cross_x == '0 && o_res.cross_y == '0)
        else $error("miss result with nonzero point");

    a_ready_tie: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seg.ready == (!o_res.valid || o_res.ready))
        else $error("input ready not tied to output drain");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

/* verif/segment_intersection_test.sv */
// ----------------------------------------------------------------------------
// segment_intersection_test: segment pair crossing testbench
// Drives segment pairs through the valid/ready input channel in bursts and
// gaps, stalls the result channel on its own pattern, and compares every
// result, in order, against its directed value or a wide-integer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_test;
    import si_pkg::*;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord ax, ay, bx, by, cx, cy, dx, dy;
    } t_pair;

    typedef struct packed {
        logic   hit;
        t_coord x;
        t_coord y;
    } t_cross;

    typedef struct {
        t_pair  p;
        logic   known;
        t_cross r;
    } t_row;

    localparam int N_RANDOM    = 1700;
    localparam int CYCLE_LIMIT = 400000;
    localparam t_coord CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam t_cross NO_HIT = '0;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    si_seg_if seg_ch ();
    si_res_if res_ch ();

    segment_intersection u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_cross crossings_due[$];
    t_row   rows[$];
    int     mismatches = 0;
    int     cycles = 0;

    function automatic t_coord lerp_coord(t_coord s, t_coord e, logic signed [127:0] num,
                                          logic signed [127:0] den);
        logic signed [127:0] d, q;
        d = 128'(signed'(e)) - 128'(signed'(s));
        q = (num * d) / den;   // truncates toward zero
        return t_coord'(128'(signed'(s)) + q);
    endfunction

    function automatic t_cross cross_point(t_pair p);
        logic signed [127:0] d1x, d1y, d2x, d2y, ox, oy, den, a, b;
        t_cross r;
        d1x = 128'(p.bx) - 128'(p.ax);
        d1y = 128'(p.by) - 128'(p.ay);
        d2x = 128'(p.dx) - 128'(p.cx);
        d2y = 128'(p.dy) - 128'(p.cy);
        ox  = 128'(p.ax) - 128'(p.cx);
        oy  = 128'(p.ay) - 128'(p.cy);
        den = d2y * d1x - d2x * d1y;
        a   = d2x * oy - d2y * ox;
        b   = d1x * oy - d1y * ox;
        r = NO_HIT;
        if (den == 0) return r;
        if (den < 0) begin
            den = -den;
            a = -a;
            b = -b;
        end
        if (a < 0 || a > den || b < 0 || b > den) return r;
        r.hit = 1'b1;
        r.x = lerp_coord(p.ax, p.bx, a, den);
        r.y = lerp_coord(p.ay, p.by, a, den);
        return r;
    endfunction

    function automatic t_coord any_coord();
        case ($urandom_range(0, 3))
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 4095)) - t_coord'(2048);
            2: return $urandom_range(0, 1) ? CMAX - t_coord'($urandom_range(0, 255))
                                           : CMIN + t_coord'($urandom_range(0, 255));
            default: return t_coord'($urandom_range(0, 1 << 16)) - t_coord'(1 << 15);
        endcase
    endfunction

    function automatic t_pair any_pair();
        t_pair p;
        int mode;
        p = {any_coord(), any_coord(), any_coord(), any_coord(),
             any_coord(), any_coord(), any_coord(), any_coord()};
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
            // second segment straddles the first: likely crossing
            p.ax = t_coord'($urandom_range(0, 8191)) - t_coord'(4096);
            p.ay = t_coord'($urandom_range(0, 8191)) - t_coord'(4096);
            p.bx = -p.ax;
            p.by = -p.ay;
            p.cx = t_coord'($urandom_range(0, 8191)) - t_coord'(4096);
            p.cy = t_coord'($urandom_range(0, 8191)) - t_coord'(4096);
            p.dx = -p.cx;
            p.dy = -p.cy;
        end else if (mode == 5) begin
            // parallel copy
            p.cx = p.ax + t_coord'(3); p.cy = p.ay + t_coord'(7);
            p.dx = p.bx + t_coord'(3); p.dy = p.by + t_coord'(7);
        end else if (mode == 6) begin
            // shared endpoint
            p.cx = p.bx; p.cy = p.by;
        end
        return p;
    endfunction

    function automatic t_row row(t_pair p, logic known, t_cross r);
        t_row w;
        w.p = p;
        w.known = known;
        w.r = r;
        return w;
    endfunction

    initial begin
        t_pair p;
        t_cross r;
        // X-shaped crossing at origin
        rows.push_back(row('{-256, -256, 256, 256, -256, 256, 256, -256}, 1'b1,
                           '{1'b1, 0, 0}));
        // parallel
        rows.push_back(row('{0, 0, 256, 0, 0, 256, 256, 256}, 1'b1, NO_HIT));
        // collinear overlapping
        rows.push_back(row('{0, 0, 512, 0, 256, 0, 768, 0}, 1'b1, NO_HIT));
        // degenerate first segment
        rows.push_back(row('{5, 5, 5, 5, 0, 0, 10, 10}, 1'b1, NO_HIT));
        // degenerate second segment
        rows.push_back(row('{0, 0, 10, 10, 3, 3, 3, 3}, 1'b1, NO_HIT));
        // touching at endpoints, both orders
        rows.push_back(row('{0, 0, 256, 0, 256, 0, 256, 256}, 1'b1, '{1'b1, 256, 0}));
        rows.push_back(row('{256, 0, 0, 0, 256, 256, 256, 0}, 1'b1, '{1'b1, 256, 0}));
        // lines cross outside first, outside second
        rows.push_back(row('{0, 0, 100, 0, 200, -50, 200, 50}, 1'b1, NO_HIT));
        rows.push_back(row('{-50, 0, 50, 0, 0, 10, 0, 60}, 1'b1, NO_HIT));
        // extremes
        rows.push_back(row('{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0, NO_HIT));
        rows.push_back(row('{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}, 1'b0, NO_HIT));
        rows.push_back(row('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, NO_HIT));
        rows.push_back(row('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1, NO_HIT));
        rows.push_back(row('{CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX}, 1'b0, NO_HIT));
        rows.push_back(row('{CMIN, CMIN, CMAX, CMAX, CMIN, -1, CMAX, 1}, 1'b0, NO_HIT));
        // truncation toward zero, both directions
        rows.push_back(row('{0, 0, 1, 3, 0, 1, 1, 0}, 1'b0, NO_HIT));
        rows.push_back(row('{0, 0, -1, -3, 0, -1, -1, 0}, 1'b0, NO_HIT));
        rows.push_back(row('{7, -3, -11, 13, -9, -9, 9, 9}, 1'b0, NO_HIT));
        foreach (rows[i]) if (rows[i].known) begin
            r = cross_point(rows[i].p);
            if (r !== rows[i].r) $display("directed row %0d predictor disagrees", i);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            p = any_pair();
            rows.push_back(row(p, 1'b0, NO_HIT));
        end
    end

    // sender: bursts and gaps
    initial begin
        int burst, gap, k;
        seg_ch.valid <= 1'b0;
        {seg_ch.first_start_x, seg_ch.first_start_y, seg_ch.first_end_x, seg_ch.first_end_y,
         seg_ch.second_start_x, seg_ch.second_start_y, seg_ch.second_end_x,
         seg_ch.second_end_y} <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        k = 0;
        while (k < rows.size()) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && k < rows.size()) begin
                seg_ch.valid <= 1'b1;
                {seg_ch.first_start_x, seg_ch.first_start_y, seg_ch.first_end_x,
                 seg_ch.first_end_y, seg_ch.second_start_x, seg_ch.second_start_y,
                 seg_ch.second_end_x, seg_ch.second_end_y} <= rows[k].p;
                @(posedge i_clk);
                while (!seg_ch.ready) @(posedge i_clk);
                crossings_due.push_back(rows[k].known ? rows[k].r : cross_point(rows[k].p));
                k++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                seg_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        seg_ch.valid <= 1'b0;
        while (crossings_due.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // receiver: stall pattern
    initial begin
        int phase;
        res_ch.ready <= 1'b0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (phase < 2000) res_ch.ready <= 1'b1;
            else res_ch.ready <= ($urandom_range(0, 99) < ((phase / 500) % 2 ? 30 : 85));
            if (phase == 6000) phase = 0;
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_cross want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (crossings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: hit=%0b x=%0d y=%0d",
                             res_ch.hit, res_ch.cross_x, res_ch.cross_y);
            end else begin
                want = crossings_due.pop_front();
                if (res_ch.hit !== want.hit || res_ch.cross_x !== want.x
                        || res_ch.cross_y !== want.y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                                 want.hit, want.x, want.y,
                                 res_ch.hit, res_ch.cross_x, res_ch.cross_y);
                end
            end
        end
    end

endmodule
